// ===== src/flqr_pkg.sv =====
// shared types, codes and fixed-point helpers for the finite-horizon lqr force block
// no dependencies; imported by every module of the block
`default_nettype none

package flqr_pkg;

    typedef logic signed [47:0] fx_t;

    localparam fx_t FX_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam fx_t FX_MIN = 48'sh8000_0000_0000;
    localparam fx_t FX_ONE = 48'sd16777216;

    localparam logic [50:0] MAG_LIM = 51'h8000_0000_0000;
    localparam logic [50:0] SAT_BIG = 51'h1_0000_0000_0000;

    // continuous model constants in q24.24
    localparam fx_t AC12 = -48'sd27430748;
    localparam fx_t AC32 = 48'sd282144838;
    localparam fx_t BC1  = 48'sd13981013;
    localparam fx_t BC3  = -48'sd23967451;

    // datapath operations
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_MAC   = 4'd2;
    localparam logic [3:0] OP_WB    = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_INITP = 4'd5;
    localparam logic [3:0] OP_CLRK  = 4'd6;
    localparam logic [3:0] OP_OUT   = 4'd7;

    // first multiplier operand sources
    localparam logic [2:0] A_P     = 3'd0;
    localparam logic [2:0] A_BTP   = 3'd1;
    localparam logic [2:0] A_K     = 3'd2;
    localparam logic [2:0] A_T     = 3'd3;
    localparam logic [2:0] A_CONST = 3'd4;

    // second operand / write-back term sources
    localparam logic [2:0] B_BD   = 3'd0;
    localparam logic [2:0] B_AD   = 3'd1;
    localparam logic [2:0] B_M    = 3'd2;
    localparam logic [2:0] B_X    = 3'd3;
    localparam logic [2:0] B_DT   = 3'd4;
    localparam logic [2:0] B_Q    = 3'd5;
    localparam logic [2:0] B_R    = 3'd6;
    localparam logic [2:0] B_ZERO = 3'd7;

    // write-back destinations
    localparam logic [2:0] DST_MODEL = 3'd0;
    localparam logic [2:0] DST_BTP   = 3'd1;
    localparam logic [2:0] DST_DEN   = 3'd2;
    localparam logic [2:0] DST_M     = 3'd3;
    localparam logic [2:0] DST_T     = 3'd4;
    localparam logic [2:0] DST_P     = 3'd5;
    localparam logic [2:0] DST_U     = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_HORIZON = 3'd0;
    localparam logic [2:0] CFG_DT      = 3'd1;
    localparam logic [2:0] CFG_FLIM    = 3'd2;
    localparam logic [2:0] CFG_QPOS    = 3'd3;
    localparam logic [2:0] CFG_QVEL    = 3'd4;
    localparam logic [2:0] CFG_QANG    = 3'd5;
    localparam logic [2:0] CFG_QRATE   = 3'd6;
    localparam logic [2:0] CFG_R       = 3'd7;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] a_sel;
        logic [3:0] a_idx;
        logic [2:0] b_sel;
        logic [3:0] b_idx;
        logic [2:0] dst;
        logic [3:0] d_idx;
        logic       neg;
        logic       ill;
    } flqr_cmd_t;

    typedef struct packed {
        logic       done;
        logic       den_pos;
        logic       out_full;
        logic [6:0] horizon;
    } flqr_stat_t;

    // signed result from a magnitude, saturating to the 48-bit range
    function automatic fx_t sat_mag(input logic [50:0] m, input logic neg);
        fx_t res;
        if (neg)
        begin
            if (m >= MAG_LIM) res = FX_MIN;
            else res = -$signed(m[47:0]);
        end
        else
        begin
            if (m >= MAG_LIM - 51'd1) res = FX_MAX;
            else res = $signed(m[47:0]);
        end
        return res;
    endfunction

    // saturate a 49-bit sum back to 48 bits
    function automatic fx_t sat_sum(input logic signed [48:0] s);
        fx_t res;
        if (s[48] != s[47]) res = s[48] ? FX_MIN : FX_MAX;
        else res = s[47:0];
        return res;
    endfunction

    function automatic logic [47:0] mag_of(input fx_t a);
        logic [47:0] res;
        if (a[47]) res = 48'(-a);
        else res = 48'(a);
        return res;
    endfunction

    function automatic fx_t model_const(input logic [1:0] idx);
        fx_t res;
        unique case (idx)
            2'd0: res = AC12;
            2'd1: res = AC32;
            2'd2: res = BC1;
            2'd3: res = BC3;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/finite_horizon_lqr_force_top.sv =====
// top level of the finite-horizon lqr force block
// depends on flqr_pkg, flqr_ctrl, flqr_dp
//
// Takes one cart-pole state request (Q16.16) and returns one clamped drive force
// plus an ill-conditioned flag. Every request rebuilds the discrete model from
// time_step, restarts the cost matrix at 2Q and runs min(horizon_steps,
// MAX_HORIZON) Riccati iterations before forming the gain. All math goes through
// one shared multiplier (one 24x24 partial product per cycle) and one bit-serial
// divider. The default horizon is 20, and the force waits until the output
// register is free. One item is in work at a time; a new request is taken as
// soon as the previous force has been handed to the output register. Configuration
// registers are read throughout the computation, so write them only while the
// block is idle.
`default_nettype none

module finite_horizon_lqr_force_top
    import flqr_pkg::*;
#(
    parameter int MAX_HORIZON = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [30:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic signed [31:0] cart_position,
    input  wire logic signed [31:0] cart_speed,
    input  wire logic signed [31:0] pole_angle,
    input  wire logic signed [31:0] pole_rate,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [31:0]     drive_force,
    output logic                   ill_conditioned
);

    flqr_cmd_t  cmd;
    flqr_stat_t st;

    // sequencer
    flqr_ctrl #(
        .MAX_HORIZON (MAX_HORIZON)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // arithmetic and storage
    flqr_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .st              (st),
        .cart_position   (cart_position),
        .cart_speed      (cart_speed),
        .pole_angle      (pole_angle),
        .pole_rate       (pole_rate),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .drive_force     (drive_force),
        .ill_conditioned (ill_conditioned)
    );

endmodule

`default_nettype wire

// ===== src/flqr_mac.sv =====
// saturating q24.24 multiplier built on one shared 24x24 multiplier, four passes
// depends on flqr_pkg
`default_nettype none

module flqr_mac
    import flqr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire fx_t  a,
    input  wire fx_t  b,
    output logic      done,
    output fx_t       prod
);

    logic        busy_reg;
    logic [1:0]  ph_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [47:0] ma_reg;
    logic [47:0] mb_reg;
    logic [50:0] r_reg;
    logic        ovf_reg;

    logic [23:0] op_a;
    logic [23:0] op_b;
    logic [47:0] pp;
    logic [48:0] lo_rnd;

    // partial product select: al*bl, ah*bl, al*bh, ah*bh
    assign op_a   = ph_reg[0] ? ma_reg[47:24] : ma_reg[23:0];
    assign op_b   = ph_reg[1] ? mb_reg[47:24] : mb_reg[23:0];
    assign pp     = op_a * op_b;
    assign lo_rnd = {1'b0, pp} + 49'h80_0000;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= 2'd0;
            end
            else if (busy_reg)
            begin
                ph_reg <= ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand magnitudes and partial sum
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= a[47] ^ b[47];
            ma_reg  <= mag_of(a);
            mb_reg  <= mag_of(b);
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            unique case (ph_reg)
                2'd0: r_reg <= 51'(lo_rnd[48:24]);
                2'd1: r_reg <= r_reg + 51'(pp);
                2'd2: r_reg <= r_reg + 51'(pp);
                2'd3:
                begin
                    r_reg   <= r_reg + {3'b0, pp[23:0], 24'b0};
                    ovf_reg <= |pp[47:24];
                end
            endcase
        end
    end

    assign done = done_reg;
    assign prod = sat_mag(ovf_reg ? SAT_BIG : r_reg, neg_reg);

endmodule

`default_nettype wire

// ===== src/flqr_div.sv =====
// bit-serial q24.24 divider, one quotient bit per cycle, rounded and saturated
// depends on flqr_pkg
`default_nettype none

module flqr_div
    import flqr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire fx_t  num,
    input  wire fx_t  den,
    output logic      done,
    output fx_t       quo
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [71:0] dvd_reg;
    logic [47:0] rem_reg;
    logic [47:0] md_reg;
    logic [47:0] q_reg;
    logic        ovf_reg;

    logic [47:0] rem2;
    logic        ge;
    logic        rnd;
    logic [48:0] qr;

    assign rem2 = {rem_reg[46:0], dvd_reg[71]};
    assign ge   = rem2 >= md_reg;
    assign rnd  = {rem_reg, 1'b0} >= {1'b0, md_reg};
    assign qr   = {1'b0, q_reg} + 49'(rnd);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd71;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring long division of |num| * 2^24 by den
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[47];
            dvd_reg <= {mag_of(num), 24'b0};
            md_reg  <= 48'(den);
            rem_reg <= 48'd0;
            q_reg   <= 48'd0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[70:0], 1'b0};
            rem_reg <= ge ? rem2 - md_reg : rem2;
            q_reg   <= {q_reg[46:0], ge};
            ovf_reg <= ovf_reg | q_reg[47];
        end
    end

    assign done = done_reg;
    assign quo  = sat_mag(ovf_reg ? SAT_BIG : 51'(qr), neg_reg);

endmodule

`default_nettype wire

// ===== src/flqr_dp.sv =====
// datapath: configuration registers, matrix storage, shared multiplier and divider
// depends on flqr_pkg, flqr_mac, flqr_div
`default_nettype none

module flqr_dp
    import flqr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [30:0]       cfg_data,
    input  wire flqr_cmd_t         cmd,
    output flqr_stat_t             st,
    input  wire logic signed [31:0] cart_position,
    input  wire logic signed [31:0] cart_speed,
    input  wire logic signed [31:0] pole_angle,
    input  wire logic signed [31:0] pole_rate,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic signed [31:0]     drive_force,
    output logic                   ill_conditioned
);

    logic [6:0]  hz_reg;
    logic [16:0] dt_reg;
    logic [30:0] flim_reg;
    logic [30:0] q_reg [4];
    logic [30:0] rw_reg;

    fx_t p_mem [16];
    fx_t m_mem [16];
    fx_t t_mem [16];
    fx_t btp_reg [4];
    fx_t k_reg [4];
    fx_t x_reg [4];
    fx_t ad6_reg;
    fx_t ad14_reg;
    fx_t bd1_reg;
    fx_t bd3_reg;
    fx_t den_reg;
    fx_t acc_reg;
    fx_t u_reg;
    logic [1:0] kidx_reg;

    logic                out_valid_reg;
    logic signed [31:0]  force_reg;
    logic                ill_reg;

    fx_t a_val;
    fx_t b_val;
    fx_t dt_fx;
    fx_t wb_val;
    fx_t mac_prod;
    fx_t div_quo;
    logic mac_done;
    logic div_done;
    logic signed [48:0] wb_sum;

    logic [47:0]        mag_u;
    logic [48:0]        rnd_u;
    logic signed [41:0] s_u;
    logic signed [41:0] flim_s;
    logic signed [41:0] clamp_u;

    assign dt_fx = {23'b0, dt_reg, 8'b0};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg   <= 7'd20;
            dt_reg   <= 17'd1311;
            flim_reg <= 31'd655360;
            q_reg[0] <= 31'd655360;
            q_reg[1] <= 31'd65536;
            q_reg[2] <= 31'd32768000;
            q_reg[3] <= 31'd3276800;
            rw_reg   <= 31'd655;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HORIZON: hz_reg   <= cfg_data[6:0];
                CFG_DT:      dt_reg   <= cfg_data[16:0];
                CFG_FLIM:    flim_reg <= cfg_data;
                CFG_QPOS:    q_reg[0] <= cfg_data;
                CFG_QVEL:    q_reg[1] <= cfg_data;
                CFG_QANG:    q_reg[2] <= cfg_data;
                CFG_QRATE:   q_reg[3] <= cfg_data;
                CFG_R:       rw_reg   <= cfg_data;
            endcase
        end
    end

    // first operand select
    always_comb
    begin
        unique case (cmd.a_sel)
            A_P:     a_val = p_mem[cmd.a_idx];
            A_BTP:   a_val = btp_reg[cmd.a_idx[1:0]];
            A_K:     a_val = k_reg[cmd.a_idx[1:0]];
            A_T:     a_val = t_mem[cmd.a_idx];
            A_CONST: a_val = model_const(cmd.a_idx[1:0]);
            default: a_val = '0;
        endcase
    end

    // second operand / term select, ad and bd are sparse
    always_comb
    begin
        unique case (cmd.b_sel)
            B_BD:
            begin
                unique case (cmd.b_idx[1:0])
                    2'd1:    b_val = bd1_reg;
                    2'd3:    b_val = bd3_reg;
                    default: b_val = '0;
                endcase
            end
            B_AD:
            begin
                unique case (cmd.b_idx)
                    4'd0, 4'd5, 4'd10, 4'd15: b_val = FX_ONE;
                    4'd1, 4'd11:              b_val = dt_fx;
                    4'd6:                     b_val = ad6_reg;
                    4'd14:                    b_val = ad14_reg;
                    default:                  b_val = '0;
                endcase
            end
            B_M:    b_val = m_mem[cmd.b_idx];
            B_X:    b_val = x_reg[cmd.b_idx[1:0]];
            B_DT:   b_val = dt_fx;
            B_Q:    b_val = {9'b0, q_reg[cmd.b_idx[1:0]], 8'b0};
            B_R:    b_val = {9'b0, rw_reg, 8'b0};
            B_ZERO: b_val = '0;
        endcase
    end

    // write-back value: term plus or minus accumulator
    assign wb_sum = cmd.neg ? ({b_val[47], b_val} - {acc_reg[47], acc_reg})
                            : ({b_val[47], b_val} + {acc_reg[47], acc_reg});
    assign wb_val = sat_sum(wb_sum);

    flqr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_MAC),
        .a     (a_val),
        .b     (b_val),
        .done  (mac_done),
        .prod  (mac_prod)
    );

    flqr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV),
        .num   (acc_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // accumulator and working storage
    always_ff @(posedge clk)
    begin
        if (mac_done)
            acc_reg <= sat_sum({acc_reg[47], acc_reg} + {mac_prod[47], mac_prod});
        else if (cmd.op == OP_WB || cmd.op == OP_DIV || cmd.op == OP_LOAD)
            acc_reg <= '0;

        if (div_done)
            k_reg[kidx_reg] <= div_quo;

        unique case (cmd.op)
            OP_LOAD:
            begin
                x_reg[0] <= {{8{cart_position[31]}}, cart_position, 8'b0};
                x_reg[1] <= {{8{cart_speed[31]}}, cart_speed, 8'b0};
                x_reg[2] <= {{8{pole_angle[31]}}, pole_angle, 8'b0};
                x_reg[3] <= {{8{pole_rate[31]}}, pole_rate, 8'b0};
            end
            OP_DIV: kidx_reg <= cmd.d_idx[1:0];
            OP_INITP:
            begin
                for (int n = 0; n < 16; n++)
                begin
                    if (n / 4 == n % 4)
                        p_mem[n] <= {8'b0, q_reg[n / 4], 9'b0};
                    else
                        p_mem[n] <= '0;
                end
            end
            OP_CLRK:
            begin
                for (int n = 0; n < 4; n++)
                    k_reg[n] <= '0;
            end
            OP_WB:
            begin
                unique case (cmd.dst)
                    DST_MODEL:
                    begin
                        unique case (cmd.d_idx[1:0])
                            2'd0: ad6_reg  <= wb_val;
                            2'd1: ad14_reg <= wb_val;
                            2'd2: bd1_reg  <= wb_val;
                            2'd3: bd3_reg  <= wb_val;
                        endcase
                    end
                    DST_BTP: btp_reg[cmd.d_idx[1:0]] <= wb_val;
                    DST_DEN: den_reg <= wb_val;
                    DST_M:   m_mem[cmd.d_idx] <= wb_val;
                    DST_T:   t_mem[cmd.d_idx] <= wb_val;
                    DST_P:   p_mem[cmd.d_idx] <= wb_val;
                    DST_U:   u_reg <= wb_val;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // round to q16.16 and clamp
    assign mag_u   = mag_of(u_reg);
    assign rnd_u   = {1'b0, mag_u} + 49'd128;
    assign s_u     = u_reg[47] ? -$signed({1'b0, rnd_u[48:8]}) : $signed({1'b0, rnd_u[48:8]});
    assign flim_s  = $signed({11'b0, flim_reg});
    always_comb
    begin
        priority if (s_u > flim_s) clamp_u = flim_s;
        else if (s_u < -flim_s) clamp_u = -flim_s;
        else clamp_u = s_u;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            force_reg <= clamp_u[31:0];
            ill_reg   <= cmd.ill;
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_force     = force_reg;
    assign ill_conditioned = ill_reg;

    assign st.done     = mac_done | div_done;
    assign st.den_pos  = !den_reg[47] && (den_reg != '0);
    assign st.out_full = out_valid_reg;
    assign st.horizon  = hz_reg;

endmodule

`default_nettype wire

// ===== src/flqr_ctrl.sv =====
// sequencer: walks the model setup, riccati iterations, gain and force steps
// depends on flqr_pkg; drives flqr_dp through command and status structs
`default_nettype none

module flqr_ctrl
    import flqr_pkg::*;
#(
    parameter int MAX_HORIZON = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire flqr_stat_t st,
    output flqr_cmd_t       cmd
);

    localparam int HW = $clog2(MAX_HORIZON + 1);
    localparam int CW = (HW > 7) ? HW : 7;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MOD_MAC  = 5'd1;
    localparam logic [4:0] S_MOD_WAIT = 5'd2;
    localparam logic [4:0] S_MOD_WB   = 5'd3;
    localparam logic [4:0] S_INITP    = 5'd4;
    localparam logic [4:0] S_ITER     = 5'd5;
    localparam logic [4:0] S_BTP_MAC  = 5'd6;
    localparam logic [4:0] S_BTP_WAIT = 5'd7;
    localparam logic [4:0] S_BTP_WB   = 5'd8;
    localparam logic [4:0] S_DEN_MAC  = 5'd9;
    localparam logic [4:0] S_DEN_WAIT = 5'd10;
    localparam logic [4:0] S_DEN_WB   = 5'd11;
    localparam logic [4:0] S_DEN_CHK  = 5'd12;
    localparam logic [4:0] S_NUM_MAC  = 5'd13;
    localparam logic [4:0] S_NUM_WAIT = 5'd14;
    localparam logic [4:0] S_NUM_DIV  = 5'd15;
    localparam logic [4:0] S_DIV_WAIT = 5'd16;
    localparam logic [4:0] S_M_MAC    = 5'd17;
    localparam logic [4:0] S_M_WAIT   = 5'd18;
    localparam logic [4:0] S_M_WB     = 5'd19;
    localparam logic [4:0] S_T_MAC    = 5'd20;
    localparam logic [4:0] S_T_WAIT   = 5'd21;
    localparam logic [4:0] S_T_WB     = 5'd22;
    localparam logic [4:0] S_P_MAC    = 5'd23;
    localparam logic [4:0] S_P_WAIT   = 5'd24;
    localparam logic [4:0] S_P_WB     = 5'd25;
    localparam logic [4:0] S_CLRK     = 5'd26;
    localparam logic [4:0] S_U_MAC    = 5'd27;
    localparam logic [4:0] S_U_WAIT   = 5'd28;
    localparam logic [4:0] S_U_WB     = 5'd29;
    localparam logic [4:0] S_OUT      = 5'd30;

    logic [4:0]    state_reg, state_next;
    logic [3:0]    ij_reg, ij_next;
    logic [1:0]    k_reg, k_next;
    logic [CW-1:0] it_reg, it_next;
    logic          ill_reg, ill_next;
    logic          fin_reg, fin_next;

    logic [1:0] ci;
    logic [1:0] cj;
    logic       more_iter;

    assign ci = ij_reg[3:2];
    assign cj = ij_reg[1:0];
    assign more_iter = (it_reg < CW'(st.horizon)) && (it_reg < CW'(MAX_HORIZON));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ij_reg    <= 4'd0;
            k_reg     <= 2'd0;
            it_reg    <= '0;
            ill_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ij_reg    <= ij_next;
            k_reg     <= k_next;
            it_reg    <= it_next;
            ill_reg   <= ill_next;
            fin_reg   <= fin_next;
        end
    end

    // sequencing and command issue
    always_comb
    begin
        state_next = state_reg;
        ij_next    = ij_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        ill_next   = ill_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.op     = OP_NOP;
        cmd.ill    = ill_reg;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    ij_next    = 4'd0;
                    k_next     = 2'd0;
                    it_next    = '0;
                    ill_next   = 1'b0;
                    fin_next   = 1'b0;
                    state_next = S_MOD_MAC;
                end
            end
            // discrete model entries from the constants and dt
            S_MOD_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_CONST;
                cmd.a_idx  = {2'b0, cj};
                cmd.b_sel  = B_DT;
                state_next = S_MOD_WAIT;
            end
            S_MOD_WAIT:
            begin
                if (st.done) state_next = S_MOD_WB;
            end
            S_MOD_WB:
            begin
                cmd.op    = OP_WB;
                cmd.dst   = DST_MODEL;
                cmd.d_idx = {2'b0, cj};
                cmd.b_sel = B_ZERO;
                if (cj == 2'd3)
                begin
                    ij_next    = 4'd0;
                    state_next = S_INITP;
                end
                else
                begin
                    ij_next    = ij_reg + 4'd1;
                    state_next = S_MOD_MAC;
                end
            end
            S_INITP:
            begin
                cmd.op     = OP_INITP;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                fin_next   = !more_iter;
                state_next = S_BTP_MAC;
            end
            // btp[j] = sum bd[k] * p[k][j]
            S_BTP_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_P;
                cmd.a_idx  = {k_reg, cj};
                cmd.b_sel  = B_BD;
                cmd.b_idx  = {2'b0, k_reg};
                state_next = S_BTP_WAIT;
            end
            S_BTP_WAIT:
            begin
                if (st.done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_BTP_WB : S_BTP_MAC;
                end
            end
            S_BTP_WB:
            begin
                cmd.op    = OP_WB;
                cmd.dst   = DST_BTP;
                cmd.d_idx = {2'b0, cj};
                cmd.b_sel = B_ZERO;
                if (cj == 2'd3)
                begin
                    ij_next    = 4'd0;
                    state_next = S_DEN_MAC;
                end
                else
                begin
                    ij_next    = ij_reg + 4'd1;
                    state_next = S_BTP_MAC;
                end
            end
            // denominator r + btp . bd
            S_DEN_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_BTP;
                cmd.a_idx  = {2'b0, k_reg};
                cmd.b_sel  = B_BD;
                cmd.b_idx  = {2'b0, k_reg};
                state_next = S_DEN_WAIT;
            end
            S_DEN_WAIT:
            begin
                if (st.done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_DEN_WB : S_DEN_MAC;
                end
            end
            S_DEN_WB:
            begin
                cmd.op     = OP_WB;
                cmd.dst    = DST_DEN;
                cmd.b_sel  = B_R;
                state_next = S_DEN_CHK;
            end
            S_DEN_CHK:
            begin
                if (st.den_pos)
                    state_next = S_NUM_MAC;
                else
                begin
                    ill_next = 1'b1;
                    if (fin_reg)
                        state_next = S_CLRK;
                    else
                    begin
                        fin_next   = 1'b1;
                        state_next = S_BTP_MAC;
                    end
                end
            end
            // gain numerator btp . ad[:][j], then divide
            S_NUM_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_BTP;
                cmd.a_idx  = {2'b0, k_reg};
                cmd.b_sel  = B_AD;
                cmd.b_idx  = {k_reg, cj};
                state_next = S_NUM_WAIT;
            end
            S_NUM_WAIT:
            begin
                if (st.done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_NUM_DIV : S_NUM_MAC;
                end
            end
            S_NUM_DIV:
            begin
                cmd.op     = OP_DIV;
                cmd.d_idx  = {2'b0, cj};
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (st.done)
                begin
                    if (cj == 2'd3)
                    begin
                        ij_next    = 4'd0;
                        state_next = fin_reg ? S_U_MAC : S_M_MAC;
                    end
                    else
                    begin
                        ij_next    = ij_reg + 4'd1;
                        state_next = S_NUM_MAC;
                    end
                end
            end
            // m = ad - bd k
            S_M_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_K;
                cmd.a_idx  = {2'b0, cj};
                cmd.b_sel  = B_BD;
                cmd.b_idx  = {2'b0, ci};
                state_next = S_M_WAIT;
            end
            S_M_WAIT:
            begin
                if (st.done) state_next = S_M_WB;
            end
            S_M_WB:
            begin
                cmd.op    = OP_WB;
                cmd.dst   = DST_M;
                cmd.d_idx = ij_reg;
                cmd.b_sel = B_AD;
                cmd.b_idx = ij_reg;
                cmd.neg   = 1'b1;
                ij_next   = ij_reg + 4'd1;
                state_next = (ij_reg == 4'd15) ? S_T_MAC : S_M_MAC;
            end
            // t = p m
            S_T_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_P;
                cmd.a_idx  = {ci, k_reg};
                cmd.b_sel  = B_M;
                cmd.b_idx  = {k_reg, cj};
                state_next = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (st.done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_T_WB : S_T_MAC;
                end
            end
            S_T_WB:
            begin
                cmd.op     = OP_WB;
                cmd.dst    = DST_T;
                cmd.d_idx  = ij_reg;
                cmd.b_sel  = B_ZERO;
                ij_next    = ij_reg + 4'd1;
                state_next = (ij_reg == 4'd15) ? S_P_MAC : S_T_MAC;
            end
            // p = q + ad' t
            S_P_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_T;
                cmd.a_idx  = {k_reg, cj};
                cmd.b_sel  = B_AD;
                cmd.b_idx  = {k_reg, ci};
                state_next = S_P_WAIT;
            end
            S_P_WAIT:
            begin
                if (st.done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_P_WB : S_P_MAC;
                end
            end
            S_P_WB:
            begin
                cmd.op    = OP_WB;
                cmd.dst   = DST_P;
                cmd.d_idx = ij_reg;
                cmd.b_sel = (ci == cj) ? B_Q : B_ZERO;
                cmd.b_idx = {2'b0, ci};
                ij_next   = ij_reg + 4'd1;
                if (ij_reg == 4'd15)
                begin
                    it_next    = it_reg + CW'(1);
                    state_next = S_ITER;
                end
                else
                    state_next = S_P_MAC;
            end
            S_CLRK:
            begin
                cmd.op     = OP_CLRK;
                state_next = S_U_MAC;
            end
            // u = -(k . x)
            S_U_MAC:
            begin
                cmd.op     = OP_MAC;
                cmd.a_sel  = A_K;
                cmd.a_idx  = {2'b0, k_reg};
                cmd.b_sel  = B_X;
                cmd.b_idx  = {2'b0, k_reg};
                state_next = S_U_WAIT;
            end
            S_U_WAIT:
            begin
                if (st.done)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_U_WB : S_U_MAC;
                end
            end
            S_U_WB:
            begin
                cmd.op     = OP_WB;
                cmd.dst    = DST_U;
                cmd.b_sel  = B_ZERO;
                cmd.neg    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!st.out_full)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/finite_horizon_lqr_force_top_tb.sv =====
// self-checking bench for finite_horizon_lqr_force_top: random and directed state requests
// depends on flqr_pkg and the rtl of the block; own fixed-point predictor of the lqr force
`timescale 1ns / 1ps

module finite_horizon_lqr_force_top_tb;
    import flqr_pkg::*;

    localparam int HORIZON_CAP = 64;
    localparam int LONG_HOLD = 20000;

    typedef longint mat16_t [16];
    typedef longint vec4_t [4];

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] spd;
        logic [31:0] ang;
        logic [31:0] rate;
    } sample_t;

    typedef struct packed {
        logic [31:0] force_q16;
        logic        ill;
    } force_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [30:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] cart_position;
    logic signed [31:0] cart_speed;
    logic signed [31:0] pole_angle;
    logic signed [31:0] pole_rate;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] drive_force;
    logic ill_conditioned;

    // bench state
    sample_t sample_q[$];
    force_t force_q[$];
    int unsent_count;
    int sender_gap_pct;
    int sink_stall_pct;
    bit hold_arm;
    bit hold_done;
    int hold_left;
    int mismatches;
    logic [30:0] cfg_shadow [8];

    finite_horizon_lqr_force_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cart_position(cart_position),
        .cart_speed(cart_speed),
        .pole_angle(pole_angle),
        .pole_rate(pole_rate),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .drive_force(drive_force),
        .ill_conditioned(ill_conditioned)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // saturating q24.24 arithmetic
    function automatic longint clamp_mag(input bit [63:0] m, input bit neg);
        if (neg)
        begin
            if (m > 64'h8000_0000_0000) m = 64'h8000_0000_0000;
            return -longint'(m);
        end
        if (m > 64'h7FFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF;
        return longint'(m);
    endfunction

    function automatic bit [63:0] abs_u(input longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return s;
    endfunction

    function automatic longint mul_round(input longint a, input longint b);
        bit neg;
        bit [63:0] ma, mb, ah, al, bh, bl, hh, r;
        neg = (a < 0) != (b < 0);
        ma = abs_u(a);
        mb = abs_u(b);
        ah = ma >> 24;
        al = ma & 64'hFF_FFFF;
        bh = mb >> 24;
        bl = mb & 64'hFF_FFFF;
        hh = ah * bh;
        if (hh >= (64'd1 << 24)) return clamp_mag(64'd1 << 48, neg);
        r = (hh << 24) + ah * bl + al * bh + ((al * bl + 64'h80_0000) >> 24);
        return clamp_mag(r, neg);
    endfunction

    function automatic longint div_round(input longint n, input longint d);
        bit neg;
        bit [63:0] mn, md, q, rem;
        neg = n < 0;
        mn = abs_u(n);
        md = 64'(d);
        q = mn / md;
        rem = mn % md;
        if (q >= (64'd1 << 24)) return clamp_mag(64'd1 << 48, neg);
        for (int i = 0; i < 24; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= md)
            begin
                rem = rem - md;
                q = q | 64'd1;
            end
        end
        if ((rem << 1) >= md) q = q + 64'd1;
        return clamp_mag(q, neg);
    endfunction

    // gain row from cost matrix; returns 0 when the denominator is not positive
    function automatic bit lqr_gain(input mat16_t p, input mat16_t ad, input vec4_t bd,
                                    input longint r, output vec4_t k);
        vec4_t btp;
        longint den, acc;
        k = '{0, 0, 0, 0};
        for (int j = 0; j < 4; j++)
        begin
            acc = 0;
            for (int i = 0; i < 4; i++) acc = add_sat(acc, mul_round(bd[i], p[i * 4 + j]));
            btp[j] = acc;
        end
        den = 0;
        for (int j = 0; j < 4; j++) den = add_sat(den, mul_round(btp[j], bd[j]));
        den = add_sat(r, den);
        if (den <= 0) return 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            acc = 0;
            for (int i = 0; i < 4; i++) acc = add_sat(acc, mul_round(btp[i], ad[i * 4 + j]));
            k[j] = div_round(acc, den);
        end
        return 1'b1;
    endfunction

    // expected force for one state sample under the current register settings
    function automatic force_t predict_force(input sample_t s);
        mat16_t ad, p, m, t;
        vec4_t bd, qd, k, x;
        longint dt, r, acc, u, flim;
        bit [63:0] mu;
        int hz;
        bit ill;
        force_t res;
        dt = longint'(cfg_shadow[CFG_DT]) << 8;
        r = longint'(cfg_shadow[CFG_R]) << 8;
        flim = longint'(cfg_shadow[CFG_FLIM]);
        hz = int'(cfg_shadow[CFG_HORIZON]);
        if (hz > HORIZON_CAP) hz = HORIZON_CAP;
        ill = 1'b0;
        for (int i = 0; i < 16; i++) ad[i] = 0;
        for (int i = 0; i < 4; i++) ad[i * 5] = 64'sd16777216;
        ad[1] = dt;
        ad[11] = dt;
        ad[6] = mul_round(AC12, dt);
        ad[14] = mul_round(AC32, dt);
        bd = '{0, mul_round(BC1, dt), 0, mul_round(BC3, dt)};
        for (int i = 0; i < 4; i++) qd[i] = longint'(cfg_shadow[CFG_QPOS + i]) << 8;
        for (int i = 0; i < 16; i++) p[i] = 0;
        for (int i = 0; i < 4; i++) p[i * 5] = qd[i] * 2;
        // backward riccati sweep
        for (int it = 0; it < hz; it++)
        begin
            if (!lqr_gain(p, ad, bd, r, k))
            begin
                ill = 1'b1;
                break;
            end
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    m[i * 4 + j] = add_sat(ad[i * 4 + j], -mul_round(bd[i], k[j]));
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                begin
                    acc = 0;
                    for (int n = 0; n < 4; n++)
                        acc = add_sat(acc, mul_round(p[i * 4 + n], m[n * 4 + j]));
                    t[i * 4 + j] = acc;
                end
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                begin
                    acc = 0;
                    for (int n = 0; n < 4; n++)
                        acc = add_sat(acc, mul_round(ad[n * 4 + i], t[n * 4 + j]));
                    p[i * 4 + j] = add_sat(i == j ? qd[i] : 0, acc);
                end
        end
        // final gain and clamped force
        if (!lqr_gain(p, ad, bd, r, k)) ill = 1'b1;
        x = '{longint'($signed(s.pos)), longint'($signed(s.spd)),
              longint'($signed(s.ang)), longint'($signed(s.rate))};
        acc = 0;
        for (int j = 0; j < 4; j++) acc = add_sat(acc, mul_round(k[j], x[j] * 256));
        u = add_sat(0, -acc);
        mu = (abs_u(u) + 64'd128) >> 8;
        u = u < 0 ? -longint'(mu) : longint'(mu);
        if (u > flim) u = flim;
        if (u < -flim) u = -flim;
        res.force_q16 = u[31:0];
        res.ill = ill;
        return res;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        sample_t s;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                force_q.push_back(predict_force({cart_position, cart_speed,
                                                 pole_angle, pole_rate}));
                unsent_count = unsent_count - 1;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_q.size() > 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    s = sample_q.pop_front();
                    cart_position <= s.pos;
                    cart_speed <= s.spd;
                    pole_angle <= s.ang;
                    pole_rate <= s.rate;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= $urandom_range(99) >= sink_stall_pct;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        force_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (force_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result: force %h ill %b", drive_force,
                             ill_conditioned);
            end
            else
            begin
                want = force_q.pop_front();
                if (drive_force !== want.force_q16 || ill_conditioned !== want.ill)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: force exp %h got %h, ill exp %b got %b",
                                 want.force_q16, drive_force, want.ill, ill_conditioned);
                end
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HORIZON: cfg_shadow[idx] = val & 31'h7F;
            CFG_DT:      cfg_shadow[idx] = val & 31'h1FFFF;
            default:     cfg_shadow[idx] = val;
        endcase
    endtask

    task automatic queue_sample(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] d);
        unsent_count = unsent_count + 1;
        sample_q.push_back({a, b, c, d});
    endtask

    // block idle once every request has been taken and answered
    task automatic drain;
        do @(posedge clk); while (unsent_count != 0 || force_q.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_state_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($urandom_range(131071)) - 32'd65536;
            2: return 32'($urandom_range(4194303)) - 32'd2097152;
            3: return 32'($urandom_range(2047)) - 32'd1024;
            default:
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0;
                endcase
        endcase
    endfunction

    function automatic logic [30:0] pick_weight();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(0, 1 << 26));
            default: return 31'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HORIZON;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cart_position = '0;
        cart_speed = '0;
        pole_angle = '0;
        pole_rate = '0;
        unsent_count = 0;
        mismatches = 0;
        hold_arm = 1'b0;
        sender_gap_pct = 16;
        sink_stall_pct = 87;
        cfg_shadow = '{31'd20, 31'd1311, 31'd655360, 31'd655360, 31'd65536,
                       31'd32768000, 31'd3276800, 31'd655};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings
        queue_sample(32'h0, 32'h0, 32'h0, 32'h0);
        queue_sample(32'h0001_0000, 32'hFFFF_8000, 32'h0000_0CCD, 32'hFFFF_F000);
        queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();

        // dt of 1.0, largest weights and clamp, smallest effort
        cfg_write(CFG_HORIZON, 31'd1);
        cfg_write(CFG_DT, 31'd65536);
        cfg_write(CFG_FLIM, 31'h7FFF_FFFF);
        cfg_write(CFG_QPOS, 31'h7FFF_FFFF);
        cfg_write(CFG_QVEL, 31'h7FFF_FFFF);
        cfg_write(CFG_QANG, 31'h7FFF_FFFF);
        cfg_write(CFG_QRATE, 31'h7FFF_FFFF);
        cfg_write(CFG_R, 31'd1);
        queue_sample(32'h0, 32'h0, 32'h0, 32'h0);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_sample(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        // gentle model with tiny effort weight, moderate clamp
        cfg_write(CFG_DT, 31'd655);
        cfg_write(CFG_FLIM, 31'd655360);
        cfg_write(CFG_QPOS, 31'd65536);
        cfg_write(CFG_QVEL, 31'd65536);
        cfg_write(CFG_QANG, 31'd655360);
        cfg_write(CFG_QRATE, 31'd65536);
        cfg_write(CFG_R, 31'd655);
        queue_sample(32'h0001_0000, 32'h0, 32'h0000_1000, 32'h0);
        queue_sample(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_F000, 32'h0000_2000);
        drain();

        // zero horizon, zero dt, zero effort, zero weights, zero clamp
        cfg_write(CFG_HORIZON, 31'd0);
        cfg_write(CFG_DT, 31'd0);
        cfg_write(CFG_R, 31'd0);
        cfg_write(CFG_FLIM, 31'd0);
        cfg_write(CFG_QPOS, 31'd0);
        cfg_write(CFG_QVEL, 31'd0);
        cfg_write(CFG_QANG, 31'd0);
        cfg_write(CFG_QRATE, 31'd0);
        queue_sample(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        drain();
        cfg_write(CFG_DT, 31'd1);
        cfg_write(CFG_FLIM, 31'h7FFF_FFFF);
        cfg_write(CFG_QANG, 31'd655360);
        queue_sample(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
        drain();

        // horizon beyond the cap runs the full sweep
        cfg_write(CFG_HORIZON, 31'd127);
        cfg_write(CFG_DT, 31'd1311);
        cfg_write(CFG_R, 31'd655);
        queue_sample(32'h0000_8000, 32'hFFFF_C000, 32'h0000_0800, 32'h0000_1000);
        drain();

        // random settings; idling pattern changes over the phases
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                sender_gap_pct = 87;
                sink_stall_pct = 16;
            end
            if (ph == 4)
            begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            cfg_write(CFG_HORIZON, ph == 5 ? 31'd8 : 31'($urandom_range(1, 4)));
            cfg_write(CFG_DT, $urandom_range(1) ? 31'($urandom_range(1, 65536))
                                               : 31'($urandom_range(300, 3000)));
            cfg_write(CFG_FLIM, $urandom_range(1) ? 31'($urandom)
                                                 : 31'($urandom_range(0, 1 << 22)));
            cfg_write(CFG_QPOS, pick_weight());
            cfg_write(CFG_QVEL, pick_weight());
            cfg_write(CFG_QANG, pick_weight());
            cfg_write(CFG_QRATE, pick_weight());
            cfg_write(CFG_R, $urandom_range(1) ? 31'($urandom_range(1, 1 << 20))
                                              : 31'($urandom));
            for (int n = 0; n < 16; n++)
                queue_sample(pick_state_value(), pick_state_value(),
                             pick_state_value(), pick_state_value());
            // sink holds off while requests keep coming
            if (ph == 3) hold_arm = 1'b1;
            drain();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && force_q.size() == 0)
            $display("PASS finite_horizon_lqr_force_top");
        else
            $display("FAIL finite_horizon_lqr_force_top");
        $finish;
    end

    // overall run limit
    initial
    begin
        #80_000_000;
        $display("FAIL finite_horizon_lqr_force_top");
        $finish;
    end

endmodule
